// File: design/wxa_pkg.sv
package wxa_pkg;

    localparam int NUM_INPUTS  = 8;
    localparam int NUM_OUTPUTS = 8;
    localparam int QUEUE_DEPTH = 8;

    localparam int PORT_W    = 4;
    localparam int IN_IDX_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int OUT_IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int QH_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SA_W      = $clog2(NUM_OUTPUTS * QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_HEAD     = 2'd0,
        CMD_TRAVERSE = 2'd1,
        CMD_STOP_SET = 2'd2,
        CMD_STOP_CLR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        K_GRANT   = 4'd0,
        K_QUEUED  = 4'd1,
        K_FULL    = 4'd2,
        K_FORWARD = 4'd3,
        K_RETRY   = 4'd4,
        K_NOCONN  = 4'd5,
        K_STOP    = 4'd6,
        K_RELEASE = 4'd7,
        K_IGNORED = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_WAITING = 2'd1,
        ST_CONNECT = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t              command;
        logic [PORT_W-1:0] port;
        logic [PORT_W-1:0] dest_port;
        logic              is_tail;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [PORT_W-1:0] input_port;
        logic [PORT_W-1:0] out_port;
        logic              last;
    } result_t;

    function automatic logic in_ok(input logic [PORT_W-1:0] p);
        return (p != '0) && (int'(p) <= NUM_INPUTS);
    endfunction

    function automatic logic out_ok(input logic [PORT_W-1:0] p);
        return (p != '0) && (int'(p) <= NUM_OUTPUTS);
    endfunction

endpackage

// File: design/wxa_req_store.sv
module wxa_req_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic [wxa_pkg::SA_W-1:0]  waddr,
    input  logic [wxa_pkg::PORT_W-1:0] wdata,
    input  logic [wxa_pkg::SA_W-1:0]  raddr,
    output logic [wxa_pkg::PORT_W-1:0] rdata
);
    import wxa_pkg::*;

    logic [PORT_W-1:0] mem [NUM_OUTPUTS*QUEUE_DEPTH];
    logic [PORT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/wormhole_crossbar_allocator_unit.sv
// Switch allocator for a wormhole crossbar, ports numbered from 1.
// Command channel: an item (head request, traverse, stop raised, stop
// lowered) is taken on a rising edge with start high and busy low.
// Result channel: result_valid marks each result for exactly one cycle;
// the receiver has no way to hold results off. An item gives one or two
// results, the final one flagged by last.
// Timing: the first result appears in the cycle after the item is taken,
// or in DEQ, the state after EVAL, when a tail traverse pops a request queue.
// Single-result items pass through EVAL only; head requests that are
// granted or queued add SECOND; a tail traverse on an output with waiting
// requests adds DEQ, and SECOND as well when the queue head is granted.
// The per-item cost is set by the table read-modify-write in EVAL plus
// the request-store read in DEQ when a queue is popped.
// Per-port tables live in small register files; the per-output request
// queues share one synchronous memory with a registered read.
// Reset clears all connections, stop marks and queue pointers at once;
// queue memory contents need no clearing and the block is ready the
// cycle after reset is released.
module wormhole_crossbar_allocator_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  wxa_pkg::item_t   item,
    output logic             result_valid,
    output wxa_pkg::result_t result
);
    import wxa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_DEQ    = 4'b0100,
        S_SECOND = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    cmd_t              cmd_reg;
    logic [PORT_W-1:0] port_reg;
    logic [PORT_W-1:0] dest_reg;
    logic              tail_reg;
    logic [PORT_W-1:0] deq_op_reg, deq_op_next;
    result_t           r2_reg, r2_next;

    logic [PORT_W-1:0] in_assign_reg [NUM_INPUTS];
    status_t           in_status_reg [NUM_INPUTS];
    logic [PORT_W-1:0] out_owner_reg [NUM_OUTPUTS];
    logic              out_stop_reg  [NUM_OUTPUTS];
    logic [QH_W-1:0]   q_head_reg    [NUM_OUTPUTS];
    logic [QC_W-1:0]   q_count_reg   [NUM_OUTPUTS];

    // table write ports, one per table; queue head and count share one
    logic                 ia_we;
    logic [IN_IDX_W-1:0]  ia_idx;
    logic [PORT_W-1:0]    ia_data;
    logic                 is_we;
    logic [IN_IDX_W-1:0]  is_idx;
    status_t              is_data;
    logic                 oo_we;
    logic [OUT_IDX_W-1:0] oo_idx;
    logic [PORT_W-1:0]    oo_data;
    logic                 os_we;
    logic                 os_data;
    logic                 q_we;
    logic [QH_W-1:0]      qh_data;
    logic [QC_W-1:0]      qc_data;

    logic              st_we;
    logic [SA_W-1:0]   st_waddr;
    logic [SA_W-1:0]   st_raddr;
    logic [PORT_W-1:0] st_rdata;

    // lookups for the item held in EVAL
    logic [IN_IDX_W-1:0]  ip_idx;
    logic [PORT_W-1:0]    asg;
    logic [PORT_W-1:0]    op;
    logic [OUT_IDX_W-1:0] op_idx;
    logic [PORT_W-1:0]    owner;
    logic [IN_IDX_W-1:0]  own_idx;
    logic [IN_IDX_W-1:0]  st_idx;
    status_t              st;
    logic                 stopped;
    logic [QH_W-1:0]      qh;
    logic [QC_W-1:0]      qc;
    logic [QC_W:0]        qsum;
    logic [QH_W-1:0]      qslot;
    logic [QH_W-1:0]      qh_inc;

    logic [OUT_IDX_W-1:0] deq_idx;
    logic [IN_IDX_W-1:0]  nx_idx;
    logic                 nx_ok;

    result_t r1;
    logic    has2;
    logic    deq;

    wxa_req_store u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (port_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_comb
    begin
        ip_idx = IN_IDX_W'(port_reg - 4'd1);
        asg    = in_assign_reg[ip_idx];
        case (cmd_reg)
            CMD_HEAD:     op = dest_reg;
            CMD_TRAVERSE: op = asg;
            default:      op = port_reg;
        endcase
        op_idx  = OUT_IDX_W'(op - 4'd1);
        owner   = out_owner_reg[op_idx];
        stopped = out_stop_reg[op_idx];
        qh      = q_head_reg[op_idx];
        qc      = q_count_reg[op_idx];
        own_idx = IN_IDX_W'(owner - 4'd1);
        st_idx  = (cmd_reg == CMD_STOP_CLR) ? own_idx : ip_idx;
        st      = in_status_reg[st_idx];

        // head + count stays below twice the depth
        qsum  = (QC_W+1)'(qh) + (QC_W+1)'(qc);
        qslot = (int'(qsum) >= QUEUE_DEPTH) ?
                QH_W'(qsum - (QC_W+1)'(QUEUE_DEPTH)) : QH_W'(qsum);
        qh_inc = (int'(qh) == QUEUE_DEPTH - 1) ? '0 : QH_W'(qh + 1'b1);

        deq_idx = OUT_IDX_W'(deq_op_reg - 4'd1);
        nx_idx  = IN_IDX_W'(st_rdata - 4'd1);
        nx_ok   = in_ok(st_rdata);
    end

    always_comb
    begin
        state_next   = state_reg;
        deq_op_next  = deq_op_reg;
        r2_next      = r2_reg;
        r1           = '{kind: K_IGNORED, input_port: '0, out_port: '0, last: 1'b0};
        has2         = 1'b0;
        deq          = 1'b0;
        result_valid = 1'b0;
        result       = r1;
        ia_we = 1'b0; ia_idx = ip_idx;  ia_data = op;
        is_we = 1'b0; is_idx = ip_idx;  is_data = ST_FREE;
        oo_we = 1'b0; oo_idx = op_idx;  oo_data = port_reg;
        os_we = 1'b0; os_data = 1'b0;
        q_we  = 1'b0; qh_data = qh;     qc_data = qc;
        st_we    = 1'b0;
        st_waddr = SA_W'(int'(op_idx) * QUEUE_DEPTH) + SA_W'(qslot);
        st_raddr = SA_W'(int'(op_idx) * QUEUE_DEPTH) + SA_W'(qh);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                case (cmd_reg)
                    CMD_HEAD:
                    begin
                        if (!(in_ok(port_reg) && out_ok(dest_reg)))
                        begin
                            r1.kind = K_IGNORED;
                        end
                        else if (st != ST_FREE)
                        begin
                            r1 = '{kind: K_IGNORED, input_port: port_reg,
                                   out_port: op, last: 1'b0};
                        end
                        else if (owner == '0)
                        begin
                            r1 = '{kind: K_GRANT, input_port: port_reg,
                                   out_port: op, last: 1'b0};
                            ia_we   = 1'b1;
                            oo_we   = 1'b1;
                            is_we   = 1'b1;
                            is_data = ST_WAITING;
                            has2    = 1'b1;
                        end
                        else if (int'(qc) >= QUEUE_DEPTH)
                        begin
                            r1 = '{kind: K_FULL, input_port: port_reg,
                                   out_port: op, last: 1'b0};
                        end
                        else
                        begin
                            r1 = '{kind: K_QUEUED, input_port: port_reg,
                                   out_port: op, last: 1'b0};
                            st_we   = 1'b1;
                            q_we    = 1'b1;
                            qc_data = QC_W'(qc + 1'b1);
                            is_we   = 1'b1;
                            is_data = ST_WAITING;
                            has2    = 1'b1;
                        end
                        r2_next = '{kind: K_STOP, input_port: port_reg,
                                    out_port: op, last: 1'b1};
                    end
                    CMD_TRAVERSE:
                    begin
                        if (!in_ok(port_reg))
                        begin
                            r1.kind = K_IGNORED;
                        end
                        else if (asg == '0 || !out_ok(asg))
                        begin
                            r1 = '{kind: K_NOCONN, input_port: port_reg,
                                   out_port: '0, last: 1'b0};
                        end
                        else if (stopped)
                        begin
                            r1 = '{kind: K_RETRY, input_port: port_reg,
                                   out_port: op, last: 1'b0};
                        end
                        else
                        begin
                            r1 = '{kind: K_FORWARD, input_port: port_reg,
                                   out_port: op, last: 1'b0};
                            is_we   = 1'b1;
                            is_data = ST_CONNECT;
                            if (tail_reg)
                            begin
                                ia_we   = 1'b1;
                                ia_data = '0;
                                is_data = ST_FREE;
                                oo_we   = 1'b1;
                                oo_data = '0;
                                if (qc != '0)
                                begin
                                    q_we    = 1'b1;
                                    qh_data = qh_inc;
                                    qc_data = QC_W'(qc - 1'b1);
                                    deq     = 1'b1;
                                end
                            end
                        end
                    end
                    CMD_STOP_SET:
                    begin
                        if (out_ok(port_reg))
                        begin
                            os_we   = 1'b1;
                            os_data = 1'b1;
                            if (in_ok(owner))
                            begin
                                r1 = '{kind: K_STOP, input_port: owner,
                                       out_port: port_reg, last: 1'b0};
                            end
                            else
                            begin
                                r1.out_port = port_reg;
                            end
                        end
                    end
                    default:
                    begin
                        if (out_ok(port_reg))
                        begin
                            os_we = 1'b1;
                            if (in_ok(owner) && st == ST_CONNECT)
                            begin
                                r1 = '{kind: K_RELEASE, input_port: owner,
                                       out_port: port_reg, last: 1'b0};
                            end
                            else
                            begin
                                r1.out_port = port_reg;
                            end
                        end
                    end
                endcase
                r1.last      = !has2;
                result       = r1;
                result_valid = !deq;
                deq_op_next  = op;
                if (deq)
                begin
                    state_next = S_DEQ;
                end
                else if (has2)
                begin
                    state_next = S_SECOND;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DEQ:
            begin
                // forward result held back until the popped entry is known
                result = '{kind: K_FORWARD, input_port: port_reg,
                           out_port: deq_op_reg, last: !nx_ok};
                result_valid = 1'b1;
                r2_next = '{kind: K_GRANT, input_port: st_rdata,
                            out_port: deq_op_reg, last: 1'b1};
                if (nx_ok)
                begin
                    ia_we   = 1'b1;
                    ia_idx  = nx_idx;
                    ia_data = deq_op_reg;
                    oo_we   = 1'b1;
                    oo_idx  = deq_idx;
                    oo_data = st_rdata;
                    state_next = S_SECOND;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SECOND:
            begin
                result       = r2_reg;
                result_valid = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg  <= item.command;
            port_reg <= item.port;
            dest_reg <= item.dest_port;
            tail_reg <= item.is_tail;
        end
        deq_op_reg <= deq_op_next;
        r2_reg     <= r2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                in_assign_reg[i] <= '0;
                in_status_reg[i] <= ST_FREE;
            end
            for (int j = 0; j < NUM_OUTPUTS; j++)
            begin
                out_owner_reg[j] <= '0;
                out_stop_reg[j]  <= 1'b0;
                q_head_reg[j]    <= '0;
                q_count_reg[j]   <= '0;
            end
        end
        else
        begin
            if (ia_we)
            begin
                in_assign_reg[ia_idx] <= ia_data;
            end
            if (is_we)
            begin
                in_status_reg[is_idx] <= is_data;
            end
            if (oo_we)
            begin
                out_owner_reg[oo_idx] <= oo_data;
            end
            if (os_we)
            begin
                out_stop_reg[op_idx] <= os_data;
            end
            if (q_we)
            begin
                q_head_reg[op_idx]  <= qh_data;
                q_count_reg[op_idx] <= qc_data;
            end
        end
    end

endmodule

// File: verif/tb_wormhole_crossbar_allocator_unit.sv
module tb_wormhole_crossbar_allocator_unit;
    import wxa_pkg::*;

    localparam int STALL_LIMIT = 400;
    localparam int RAND_ITEMS  = 450;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    result_valid;
    result_t result;

    wormhole_crossbar_allocator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    // shadow copy of the allocator tables, ports numbered from 1
    int      conn_out [1:NUM_INPUTS];
    status_t in_state [1:NUM_INPUTS];
    int      owner_of [1:NUM_OUTPUTS];
    bit      stop_mark[1:NUM_OUTPUTS];
    int      req_mem  [0:NUM_OUTPUTS*QUEUE_DEPTH-1];
    int      q_rd     [1:NUM_OUTPUTS];
    int      q_cnt    [1:NUM_OUTPUTS];

    result_t pending_results[$];
    int      mismatch_cnt;
    int      stall_cnt;

    typedef struct {
        item_t   it;
        int      n_typed;
        result_t e0;
        result_t e1;
    } stim_row_t;

    stim_row_t dir_tab[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t itm(cmd_t c, int p, int d, bit t);
        item_t it;
        it.command   = c;
        it.port      = PORT_W'(p);
        it.dest_port = PORT_W'(d);
        it.is_tail   = t;
        return it;
    endfunction

    function automatic result_t res(kind_t k, int ip, int op, bit l);
        result_t r;
        r.kind       = k;
        r.input_port = PORT_W'(ip);
        r.out_port   = PORT_W'(op);
        r.last       = l;
        return r;
    endfunction

    function automatic stim_row_t row(item_t it, int n, result_t e0, result_t e1);
        stim_row_t s;
        s.it      = it;
        s.n_typed = n;
        s.e0      = e0;
        s.e1      = e1;
        return s;
    endfunction

    function automatic bit port_in_range(logic [PORT_W-1:0] p, int hi);
        return (p != 0) && (int'(p) <= hi);
    endfunction

    // expected results of one command; returns how many
    function automatic int alloc_step(input item_t it, output result_t r0, output result_t r1);
        int ip;
        int op;
        int nx;
        int n;
        r0 = '0;
        r1 = '0;
        n  = 1;
        case (it.command)
            CMD_HEAD:
            begin
                if (!port_in_range(it.port, NUM_INPUTS) ||
                    !port_in_range(it.dest_port, NUM_OUTPUTS))
                    r0 = res(K_IGNORED, 0, 0, 1'b0);
                else
                begin
                    ip = int'(it.port);
                    op = int'(it.dest_port);
                    if (in_state[ip] != ST_FREE)
                        r0 = res(K_IGNORED, ip, op, 1'b0);
                    else if (owner_of[op] == 0)
                    begin
                        conn_out[ip] = op;
                        owner_of[op] = ip;
                        in_state[ip] = ST_WAITING;
                        r0 = res(K_GRANT, ip, op, 1'b0);
                        r1 = res(K_STOP, ip, op, 1'b0);
                        n  = 2;
                    end
                    else if (q_cnt[op] >= QUEUE_DEPTH)
                        r0 = res(K_FULL, ip, op, 1'b0);
                    else
                    begin
                        req_mem[(op-1)*QUEUE_DEPTH + (q_rd[op] + q_cnt[op]) % QUEUE_DEPTH] = ip;
                        q_cnt[op]++;
                        in_state[ip] = ST_WAITING;
                        r0 = res(K_QUEUED, ip, op, 1'b0);
                        r1 = res(K_STOP, ip, op, 1'b0);
                        n  = 2;
                    end
                end
            end
            CMD_TRAVERSE:
            begin
                if (!port_in_range(it.port, NUM_INPUTS))
                    r0 = res(K_IGNORED, 0, 0, 1'b0);
                else
                begin
                    ip = int'(it.port);
                    op = conn_out[ip];
                    if (op == 0)
                        r0 = res(K_NOCONN, ip, 0, 1'b0);
                    else if (stop_mark[op])
                        r0 = res(K_RETRY, ip, op, 1'b0);
                    else
                    begin
                        in_state[ip] = ST_CONNECT;
                        r0 = res(K_FORWARD, ip, op, 1'b0);
                        if (it.is_tail)
                        begin
                            conn_out[ip] = 0;
                            in_state[ip] = ST_FREE;
                            owner_of[op] = 0;
                            if (q_cnt[op] != 0)
                            begin
                                nx = req_mem[(op-1)*QUEUE_DEPTH + q_rd[op]];
                                q_rd[op] = (q_rd[op] + 1) % QUEUE_DEPTH;
                                q_cnt[op]--;
                                if (nx >= 1 && nx <= NUM_INPUTS)
                                begin
                                    // granted input stays waiting until its first flit
                                    conn_out[nx] = op;
                                    owner_of[op] = nx;
                                    r1 = res(K_GRANT, nx, op, 1'b0);
                                    n  = 2;
                                end
                            end
                        end
                    end
                end
            end
            CMD_STOP_SET:
            begin
                if (!port_in_range(it.port, NUM_OUTPUTS))
                    r0 = res(K_IGNORED, 0, 0, 1'b0);
                else
                begin
                    op = int'(it.port);
                    stop_mark[op] = 1'b1;
                    if (owner_of[op] != 0)
                        r0 = res(K_STOP, owner_of[op], op, 1'b0);
                    else
                        r0 = res(K_IGNORED, 0, op, 1'b0);
                end
            end
            default:
            begin
                if (!port_in_range(it.port, NUM_OUTPUTS))
                    r0 = res(K_IGNORED, 0, 0, 1'b0);
                else
                begin
                    op = int'(it.port);
                    stop_mark[op] = 1'b0;
                    if (owner_of[op] != 0 && in_state[owner_of[op]] == ST_CONNECT)
                        r0 = res(K_RELEASE, owner_of[op], op, 1'b0);
                    else
                        r0 = res(K_IGNORED, 0, op, 1'b0);
                end
            end
        endcase
        if (n == 2)
            r1.last = 1'b1;
        else
            r0.last = 1'b1;
        return n;
    endfunction

    // mostly legal traffic steered by the shadow tables, some raw noise
    function automatic item_t rand_item();
        item_t                  it;
        logic [$bits(item_t)-1:0] raw;
        int                     cand[$];
        int                     r;
        r            = $urandom_range(0, 99);
        it.command   = CMD_HEAD;
        it.port      = PORT_W'($urandom_range(1, NUM_INPUTS));
        it.dest_port = PORT_W'($urandom_range(1, NUM_OUTPUTS));
        it.is_tail   = 1'($urandom_range(0, 1));
        if (r < 6)
        begin
            raw = $bits(item_t)'($urandom);
            it  = raw;
        end
        else if (r < 38)
        begin
            for (int i = 1; i <= NUM_INPUTS; i++)
                if (in_state[i] == ST_FREE)
                    cand.push_back(i);
            if (cand.size() != 0 && $urandom_range(0, 9) < 7)
                it.port = PORT_W'(cand[$urandom_range(0, cand.size()-1)]);
        end
        else if (r < 80)
        begin
            it.command = CMD_TRAVERSE;
            it.is_tail = ($urandom_range(0, 9) < 4);
            for (int i = 1; i <= NUM_INPUTS; i++)
                if (conn_out[i] != 0)
                    cand.push_back(i);
            if (cand.size() != 0 && $urandom_range(0, 99) < 85)
                it.port = PORT_W'(cand[$urandom_range(0, cand.size()-1)]);
        end
        else if (r < 88)
        begin
            it.command = CMD_STOP_SET;
            it.port    = PORT_W'($urandom_range(1, NUM_OUTPUTS));
        end
        else
        begin
            it.command = CMD_STOP_CLR;
            for (int i = 1; i <= NUM_OUTPUTS; i++)
                if (stop_mark[i])
                    cand.push_back(i);
            if (cand.size() != 0 && $urandom_range(0, 9) < 8)
                it.port = PORT_W'(cand[$urandom_range(0, cand.size()-1)]);
            else
                it.port = PORT_W'($urandom_range(1, NUM_OUTPUTS));
        end
        return it;
    endfunction

    // drive one command and hold it until the transfer happens
    task automatic issue(input item_t it, input int n_typed, input result_t t0, input result_t t1);
        result_t p0;
        result_t p1;
        int      n;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n = alloc_step(it, p0, p1);
        if (n_typed == 0)
        begin
            pending_results.push_back(p0);
            if (n == 2)
                pending_results.push_back(p1);
        end
        else
        begin
            pending_results.push_back(t0);
            if (n_typed == 2)
                pending_results.push_back(t1);
        end
    endtask

    task automatic sender_gap(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 38)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected result kind=%0d in=%0d out=%0d last=%0b",
                         $time, result.kind, result.input_port, result.out_port,
                         result.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.kind !== want.kind || result.input_port !== want.input_port ||
                    result.out_port !== want.out_port || result.last !== want.last)
                begin
                    mismatch_cnt++;
                    $display({"%0t: mismatch expected kind=%0d in=%0d out=%0d last=%0b,",
                              " actual kind=%0d in=%0d out=%0d last=%0b"},
                             $time, want.kind, want.input_port, want.out_port, want.last,
                             result.kind, result.input_port, result.out_port, result.last);
                end
            end
        end
    end

    // watchdog: any transfer on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cnt <= 0;
        else if ((start && !busy) || result_valid)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    initial
    begin
        result_t none;
        none         = '0;
        mismatch_cnt = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        for (int i = 1; i <= NUM_INPUTS; i++)
        begin
            conn_out[i] = 0;
            in_state[i] = ST_FREE;
        end
        for (int i = 1; i <= NUM_OUTPUTS; i++)
        begin
            owner_of[i]  = 0;
            stop_mark[i] = 1'b0;
            q_rd[i]      = 0;
            q_cnt[i]     = 0;
        end
        foreach (req_mem[i])
            req_mem[i] = 0;

        // range errors, reset-state responses and the first grant on output 8 are typed in directly
        dir_tab.push_back(row(itm(CMD_HEAD, 0, 1, 0), 1, res(K_IGNORED, 0, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_HEAD, 9, 1, 0), 1, res(K_IGNORED, 0, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_HEAD, 1, 0, 0), 1, res(K_IGNORED, 0, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_HEAD, 15, 15, 1), 1, res(K_IGNORED, 0, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 1, 0, 0), 1, res(K_NOCONN, 1, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 0, 15, 1), 1, res(K_IGNORED, 0, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_STOP_SET, 9, 0, 0), 1, res(K_IGNORED, 0, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_STOP_CLR, 0, 0, 0), 1, res(K_IGNORED, 0, 0, 1), none));
        dir_tab.push_back(row(itm(CMD_STOP_SET, 8, 0, 0), 1, res(K_IGNORED, 0, 8, 1), none));
        dir_tab.push_back(row(itm(CMD_HEAD, 1, 8, 0), 2, res(K_GRANT, 1, 8, 0),
                              res(K_STOP, 1, 8, 1)));
        dir_tab.push_back(row(itm(CMD_HEAD, 1, 8, 0), 1, res(K_IGNORED, 1, 8, 1), none));
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 1, 0, 0), 1, res(K_RETRY, 1, 8, 1), none));
        // owner still waiting, so lowering stop releases nobody
        dir_tab.push_back(row(itm(CMD_STOP_CLR, 8, 0, 0), 0, none, none));
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 1, 0, 0), 0, none, none));
        dir_tab.push_back(row(itm(CMD_STOP_SET, 8, 0, 0), 0, none, none));
        dir_tab.push_back(row(itm(CMD_STOP_CLR, 8, 0, 0), 0, none, none));
        dir_tab.push_back(row(itm(CMD_HEAD, 2, 8, 0), 0, none, none));
        dir_tab.push_back(row(itm(CMD_HEAD, 8, 8, 1), 0, none, none));
        dir_tab.push_back(row(itm(CMD_HEAD, 1, 1, 0), 0, none, none));
        // tails hand the output down the queue
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 1, 8, 1), 0, none, none));
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 2, 0, 1), 0, none, none));
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 8, 0, 1), 0, none, none));
        dir_tab.push_back(row(itm(CMD_TRAVERSE, 8, 0, 0), 0, none, none));

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            sender_gap(1'b0);
            if (i == 12)
                drain_results();
            issue(dir_tab[i].it, dir_tab[i].n_typed, dir_tab[i].e0, dir_tab[i].e1);
        end
        drain_results();

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            sender_gap(i >= 150 && i < 260);
            if (i % 90 == 89)
                drain_results();
            issue(rand_item(), 0, none, none);
        end

        drain_results();
        repeat (8)
            @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
design/wxa_pkg.sv
design/wxa_req_store.sv
design/wormhole_crossbar_allocator_unit.sv
verif/tb_wormhole_crossbar_allocator_unit.sv
